>>> design/vbsp_pkg.sv
// ============================================================================
// vbsp_pkg: shared types and constants of the voice block stream parser
// Holds the result word layout, the result kind codes, the header layout
// constants and the size of the queue between the parser and the output.
// ============================================================================
package vbsp_pkg;

    // Header layout of a voice file.
    localparam logic [15:0] HdrLen   = 16'd22;
    localparam logic [15:0] OfsLoPos = 16'd20;
    localparam logic [15:0] OfsHiPos = 16'd21;

    // Rate and pack bytes of a type-1 block count against its length.
    localparam logic [23:0] RatePackLen = 24'd2;

    // Result kinds.
    localparam logic [1:0] KindSample = 2'd0;
    localparam logic [1:0] KindEnd    = 2'd1;
    localparam logic [1:0] KindError  = 2'd2;

    // Queue between the parser and the output stage.
    localparam int QAw    = 2;
    localparam int QDepth = 2 ** QAw;

    // One result word.
    typedef struct packed {
        logic [7:0] sample_byte;
        logic [1:0] kind;
    } t_result;

endpackage

>>> design/vbsp_if.sv
// ============================================================================
// vbsp_if: stream interfaces of the voice block stream parser
// One interface carries file bytes into the parser, the other carries
// result words out. A word moves when valid and ready are both high.
// ============================================================================
interface vbsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface vbsp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_byte;
    logic [1:0] kind;

    modport source (output valid, output sample_byte, output kind, input ready);
    modport sink (input valid, input sample_byte, input kind, output ready);
endinterface

>>> design/vbsp_front.sv
// ============================================================================
// vbsp_front: byte classifier of the voice block stream parser
// Takes one file byte per cycle while the queue has room, tracks the header,
// skip, block type, length and data phases, and queues any result word.
// ============================================================================
module vbsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vbsp_byte_if.sink         i_byte,
    input  logic              i_full,
    output logic              o_push,
    output vbsp_pkg::t_result o_res
);
    import vbsp_pkg::*;

    // Parser phases.
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_SKIP   = 4'd1;
    localparam logic [3:0] PH_TYPE   = 4'd2;
    localparam logic [3:0] PH_LEN0   = 4'd3;
    localparam logic [3:0] PH_LEN1   = 4'd4;
    localparam logic [3:0] PH_LEN2   = 4'd5;
    localparam logic [3:0] PH_RATE   = 4'd6;
    localparam logic [3:0] PH_PACK   = 4'd7;
    localparam logic [3:0] PH_DATA   = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;

    logic [3:0]  r_phase, n_phase, w_phase;
    logic [15:0] r_hcnt, n_hcnt, w_hcnt;
    logic [15:0] r_ofs, n_ofs, w_ofs;
    logic [23:0] r_rem, n_rem, w_rem;
    logic        r_typed, n_typed, w_typed;
    logic [15:0] w_hcnt_inc;
    logic [15:0] w_ofs_hdr;
    logic [23:0] w_len;
    logic [23:0] w_dec;
    logic [7:0]  w_b;
    logic        w_accept;
    logic        w_res_valid;
    t_result     w_res;

    // A byte is taken whenever the queue has room.
    assign i_byte.ready = ~i_full;
    assign w_accept     = i_byte.valid & ~i_full;
    assign w_b          = i_byte.data_byte;

    // A start-of-file byte is parsed from the reset state.
    always_comb begin
        if (i_byte.file_start) begin
            w_phase = PH_HEADER;
            w_hcnt  = 16'd0;
            w_ofs   = 16'd0;
            w_rem   = 24'd0;
            w_typed = 1'b0;
        end else begin
            w_phase = r_phase;
            w_hcnt  = r_hcnt;
            w_ofs   = r_ofs;
            w_rem   = r_rem;
            w_typed = r_typed;
        end
    end

    // Helpers for the header, length and data phases.
    assign w_hcnt_inc = w_hcnt + 16'd1;
    assign w_len      = w_rem | {w_b, 16'd0};
    assign w_dec      = (w_rem != 24'd0) ? (w_rem - 24'd1) : w_rem;

    always_comb begin
        if (w_hcnt == OfsLoPos) begin
            w_ofs_hdr = {w_ofs[15:8], w_b};
        end else if (w_hcnt == OfsHiPos) begin
            w_ofs_hdr = {w_b, w_ofs[7:0]};
        end else begin
            w_ofs_hdr = w_ofs;
        end
    end

    // Next-state and result logic.
    always_comb begin
        n_phase     = w_phase;
        n_hcnt      = w_hcnt;
        n_ofs       = w_ofs;
        n_rem       = w_rem;
        n_typed     = w_typed;
        w_res_valid = 1'b0;
        w_res       = '{sample_byte: 8'd0, kind: KindSample};
        unique case (w_phase)
            PH_HEADER: begin
                n_ofs  = w_ofs_hdr;
                n_hcnt = w_hcnt_inc;
                if (w_hcnt_inc >= HdrLen) begin
                    if (w_ofs_hdr < HdrLen) begin
                        n_ofs = HdrLen;
                    end
                    n_phase = (w_hcnt_inc >= n_ofs) ? PH_TYPE : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_hcnt = w_hcnt_inc;
                if (w_hcnt_inc >= w_ofs) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (w_b == 8'd0) begin
                    n_phase     = PH_DONE;
                    w_res_valid = 1'b1;
                    w_res.kind  = KindEnd;
                end else if (w_b == 8'd1 || w_b == 8'd2) begin
                    n_typed = (w_b == 8'd1);
                    n_rem   = 24'd0;
                    n_phase = PH_LEN0;
                end else if (w_b <= 8'd7) begin
                    n_phase     = PH_DONE;
                    w_res_valid = 1'b1;
                    w_res.kind  = KindError;
                end
            end
            PH_LEN0: begin
                n_rem   = {16'd0, w_b};
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_rem   = w_rem | {8'd0, w_b, 8'd0};
                n_phase = PH_LEN2;
            end
            PH_LEN2: begin
                if (w_typed) begin
                    if (w_len < RatePackLen) begin
                        n_rem       = w_len;
                        n_phase     = PH_DONE;
                        w_res_valid = 1'b1;
                        w_res.kind  = KindError;
                    end else begin
                        n_rem   = w_len - RatePackLen;
                        n_phase = PH_RATE;
                    end
                end else begin
                    n_rem   = w_len;
                    n_phase = (w_len == 24'd0) ? PH_TYPE : PH_DATA;
                end
            end
            PH_RATE: begin
                n_phase = PH_PACK;
            end
            PH_PACK: begin
                n_phase = (w_rem == 24'd0) ? PH_TYPE : PH_DATA;
            end
            PH_DATA: begin
                n_rem = w_dec;
                if (w_dec == 24'd0) begin
                    n_phase = PH_TYPE;
                end
                w_res_valid       = 1'b1;
                w_res.sample_byte = w_b;
                w_res.kind        = KindSample;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Parser state advances on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hcnt  <= 16'd0;
            r_ofs   <= 16'd0;
            r_rem   <= 24'd0;
            r_typed <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_ofs   <= n_ofs;
            r_rem   <= n_rem;
            r_typed <= n_typed;
        end
    end

    assign o_push = w_accept & w_res_valid;
    assign o_res  = w_res;

endmodule

>>> design/vbsp_fifo.sv
// ============================================================================
// vbsp_fifo: result queue of the voice block stream parser
// A short first-in first-out queue that decouples the byte classifier from
// the output stage, so that each side can stall on its own.
// ============================================================================
module vbsp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vbsp_pkg::t_result i_data,
    input  logic              i_pop,
    output vbsp_pkg::t_result o_data,
    output logic              o_full,
    output logic              o_empty
);
    import vbsp_pkg::*;

    t_result          r_mem [QDepth];
    logic [QAw-1:0]   r_wr_ptr;
    logic [QAw-1:0]   r_rd_ptr;
    logic [QAw:0]     r_count;

    assign o_full  = (r_count == (QAw + 1)'(QDepth));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/vbsp_back.sv
// ============================================================================
// vbsp_back: output stage of the voice block stream parser
// Moves result words from the queue into an output register and holds each
// word until the receiver takes it.
// ============================================================================
module vbsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  vbsp_pkg::t_result i_data,
    output logic              o_pop,
    vbsp_res_if.source        o_res
);
    import vbsp_pkg::*;

    logic    r_valid;
    t_result r_data;

    // Load a new word when the register is empty or being drained.
    assign o_pop = ~i_empty & (~r_valid | o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.sample_byte = r_data.sample_byte;
    assign o_res.kind        = r_data.kind;

endmodule

>>> design/voc_block_stream_parser.sv
// ============================================================================
// voc_block_stream_parser: streaming parser for voice sound files
// Reads the header, skips to the first block and emits the sample bytes of
// each data block, plus one end or error word where the file stops.
// ============================================================================
// Usage:
//   i_byte carries one file byte per word; file_start high marks the first
//   byte of a new file and restarts the parser from that byte.
//   o_res carries result words: kind 0 is a sample in sample_byte, kind 1
//   is the end of the file, kind 2 is a format error (sample_byte zero).
//   Header, skip, rate and pack bytes give no word; type and length bytes
//   yield only end or error words, then bytes drop until the next file_start.
// Throughput: one byte per clock cycle, sustained while the queue has room;
//   the parser classifies each byte in the cycle it is accepted.
// Path: a result word enters the four-entry queue when its byte is accepted,
//   then moves into the output register and is valid on o_res there until
//   the receiver takes it.
// Stalls: when the receiver holds ready low, words collect in the queue;
//   i_byte.ready drops only once the queue is full.
// Reset: synchronous and active low; the queue and the output register are
//   emptied and the parser waits for header byte 0.
// ============================================================================
module voc_block_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vbsp_byte_if.sink   i_byte,
    vbsp_res_if.source  o_res
);
    import vbsp_pkg::*;

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_result w_front_res;
    t_result w_q_data;

    vbsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_res   (w_front_res)
    );

    vbsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_res),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    vbsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_q_data),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("result queue written while full");

    // The queue is never read while empty.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("result queue read while empty");

    // End and error words carry a zero sample byte.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind != KindSample) |-> (o_res.sample_byte == 8'd0))
        else $error("status word with nonzero sample byte");

endmodule
